// ===== rtl/ffe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the flood fill engine.
// No dependencies; every other file but ffe_ram imports this package.
package ffe_pkg;

  localparam int COLOR_W   = 32;
  localparam int OP_W      = 2;
  localparam int XIN_W     = 8;
  localparam int STATUS_W  = 2;
  localparam int DIM_REG_W = 9;
  localparam int CFG_IDX_W = 4;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_FILL  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 4'd1;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 9'd256;

  // Neighbor push order
  localparam logic [1:0] DIR_XP = 2'd0;
  localparam logic [1:0] DIR_XM = 2'd1;
  localparam logic [1:0] DIR_YP = 2'd2;
  localparam logic [1:0] DIR_YM = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SEED,
    S_POP,
    S_LOAD,
    S_CHECK,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic [COLOR_W-1:0]  read_color;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

// ===== rtl/ffe_if.sv =====
`timescale 1ns / 1ps
// Handshake channels of the flood fill engine: command, response, configuration.
// Depends on ffe_pkg for field widths.
interface ffe_cmd_if import ffe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [XIN_W-1:0]    x_coord;
  logic [XIN_W-1:0]    y_coord;
  logic [COLOR_W-1:0]  pixel_color;

  modport source (output valid, op, x_coord, y_coord, pixel_color, input ready);
  modport sink   (input valid, op, x_coord, y_coord, pixel_color, output ready);
endinterface

interface ffe_rsp_if import ffe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COLOR_W-1:0]  read_color;
  logic [STATUS_W-1:0] status;

  modport source (output valid, read_color, status, input ready);
  modport sink   (input valid, read_color, status, output ready);
endinterface

interface ffe_cfg_if import ffe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_REG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ffe_ram.sv =====
`timescale 1ns / 1ps
// Single-port synchronous RAM with a registered read; read data held between reads.
// Used for the canvas and the coordinate stack; no dependencies.
module ffe_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/ffe_outq.sv =====
`timescale 1ns / 1ps
// Two-entry response queue between the sequencer and the response channel.
// Depends on ffe_pkg (res_t) and ffe_if (ffe_rsp_if).
module ffe_outq import ffe_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  res_t          res,
  output logic          space,
  ffe_rsp_if.source     rsp
);

  res_t       slot0;
  res_t       slot1;
  logic [1:0] count;
  logic       pop;

  assign pop            = rsp.valid && rsp.ready;
  assign space          = (count != 2'd2);
  assign rsp.valid      = (count != 2'd0);
  assign rsp.read_color = slot0.read_color;
  assign rsp.status     = slot0.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // A push never meets a full queue, so push with pop only happens at one entry.
  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          slot0 <= res;
        end else begin
          slot1 <= res;
        end
      end
      2'b01: begin
        slot0 <= slot1;
      end
      2'b11: begin
        slot0 <= res;
      end
      default: begin
        slot0 <= slot0;
      end
    endcase
  end

endmodule

// ===== rtl/ffe_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: pixel write/read and the stack-driven flood fill over the canvas RAM.
// Depends on ffe_pkg and ffe_if (ffe_cmd_if).
module ffe_ctrl import ffe_pkg::*; #(
  parameter int MAX_DIM     = 256,
  parameter int STACK_DEPTH = 4096,
  localparam int CW  = $clog2(MAX_DIM),
  localparam int DW  = CW + 1,
  localparam int CAW = 2 * CW,
  localparam int SAW = $clog2(STACK_DEPTH),
  localparam int LW  = $clog2(STACK_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  ffe_cmd_if.sink            cmd,
  input  logic [DW-1:0]      w_eff,
  input  logic [DW-1:0]      h_eff,
  output logic               canvas_we,
  output logic               canvas_re,
  output logic [CAW-1:0]     canvas_addr,
  output logic [COLOR_W-1:0] canvas_wdata,
  input  logic [COLOR_W-1:0] canvas_rdata,
  output logic               stack_we,
  output logic               stack_re,
  output logic [SAW-1:0]     stack_addr,
  output logic [CAW-1:0]     stack_wdata,
  input  logic [CAW-1:0]     stack_rdata,
  output logic               res_push,
  output res_t               res,
  input  logic               res_space
);

  state_t             state, state_next;
  logic [COLOR_W-1:0] fill_color, fill_color_next;
  logic [COLOR_W-1:0] target, target_next;
  logic [CW-1:0]      cur_x, cur_x_next;
  logic [CW-1:0]      cur_y, cur_y_next;
  logic [LW-1:0]      level, level_next;
  logic [1:0]         dir, dir_next;

  logic               acc;
  logic               cmd_inside;
  logic [CW-1:0]      cmd_x;
  logic [CW-1:0]      cmd_y;
  logic [LW-1:0]      level_dec;
  logic               stack_full;
  logic [CW-1:0]      pop_x;
  logic [CW-1:0]      pop_y;
  logic               pop_inside;
  logic               nbr_ok;
  logic [CW-1:0]      nbr_x;
  logic [CW-1:0]      nbr_y;

  assign cmd.ready  = (state == S_IDLE) && res_space;
  assign acc        = cmd.valid && cmd.ready;
  assign cmd_inside = (32'(cmd.x_coord) < 32'(w_eff)) && (32'(cmd.y_coord) < 32'(h_eff));
  assign cmd_x      = CW'(cmd.x_coord);
  assign cmd_y      = CW'(cmd.y_coord);
  assign level_dec  = level - LW'(1);
  assign stack_full = (level == LW'(STACK_DEPTH));
  assign pop_x      = stack_rdata[CW-1:0];
  assign pop_y      = stack_rdata[CAW-1:CW];
  assign pop_inside = (DW'(pop_x) < w_eff) && (DW'(pop_y) < h_eff);

  always_comb begin
    nbr_x = cur_x;
    nbr_y = cur_y;
    unique case (dir)
      DIR_XP: begin
        nbr_ok = (DW'(cur_x) + DW'(1)) < w_eff;
        nbr_x  = cur_x + CW'(1);
      end
      DIR_XM: begin
        nbr_ok = (cur_x != '0);
        nbr_x  = cur_x - CW'(1);
      end
      DIR_YP: begin
        nbr_ok = (DW'(cur_y) + DW'(1)) < h_eff;
        nbr_y  = cur_y + CW'(1);
      end
      default: begin
        nbr_ok = (cur_y != '0);
        nbr_y  = cur_y - CW'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      level  <= '0;
      target <= '0;
    end else begin
      state  <= state_next;
      level  <= level_next;
      target <= target_next;
    end
  end

  always_ff @(posedge clk) begin
    fill_color <= fill_color_next;
    cur_x      <= cur_x_next;
    cur_y      <= cur_y_next;
    dir        <= dir_next;
  end

  always_comb begin
    state_next      = state;
    fill_color_next = fill_color;
    target_next     = target;
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    level_next      = level;
    dir_next        = dir;
    canvas_we       = 1'b0;
    canvas_re       = 1'b0;
    canvas_addr     = {cur_y, cur_x};
    canvas_wdata    = fill_color;
    stack_we        = 1'b0;
    stack_re        = 1'b0;
    stack_addr      = level[SAW-1:0];
    stack_wdata     = {cur_y, cur_x};
    res_push        = 1'b0;
    res.read_color  = '0;
    res.status      = STAT_OK;

    unique case (state)
      S_IDLE: begin
        canvas_addr  = {cmd_y, cmd_x};
        canvas_wdata = cmd.pixel_color;
        if (acc) begin
          priority if (cmd.op == OP_WRITE) begin
            canvas_we  = cmd_inside;
            res_push   = 1'b1;
            res.status = cmd_inside ? STAT_OK : STAT_RANGE;
          end else if (cmd.op == OP_READ || cmd.op == OP_FILL) begin
            if (cmd_inside) begin
              canvas_re       = 1'b1;
              cur_x_next      = cmd_x;
              cur_y_next      = cmd_y;
              fill_color_next = cmd.pixel_color;
              state_next      = (cmd.op == OP_READ) ? S_READ : S_SEED;
            end else begin
              res_push   = 1'b1;
              res.status = STAT_RANGE;
            end
          end else begin
            res_push = 1'b1;
          end
        end
      end

      S_READ: begin
        if (res_space) begin
          res_push       = 1'b1;
          res.read_color = canvas_rdata;
          state_next     = S_IDLE;
        end
      end

      S_SEED: begin
        target_next = canvas_rdata;
        if (canvas_rdata == fill_color) begin
          if (res_space) begin
            res_push   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          stack_we   = 1'b1;
          stack_addr = '0;
          level_next = LW'(1);
          state_next = S_POP;
        end
      end

      S_POP: begin
        stack_addr = level_dec[SAW-1:0];
        if (level == '0) begin
          if (res_space) begin
            res_push   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          stack_re   = 1'b1;
          level_next = level_dec;
          state_next = S_LOAD;
        end
      end

      S_LOAD: begin
        cur_x_next  = pop_x;
        cur_y_next  = pop_y;
        canvas_addr = stack_rdata;
        if (pop_inside) begin
          canvas_re  = 1'b1;
          state_next = S_CHECK;
        end else begin
          state_next = S_POP;
        end
      end

      S_CHECK: begin
        if (canvas_rdata == target) begin
          canvas_we  = 1'b1;
          dir_next   = DIR_XP;
          state_next = S_PUSH;
        end else begin
          state_next = S_POP;
        end
      end

      S_PUSH: begin
        stack_wdata = {nbr_y, nbr_x};
        if (nbr_ok && stack_full) begin
          // Overflow: drop the stack and report
          if (res_space) begin
            res_push   = 1'b1;
            res.status = STAT_OVERFLOW;
            level_next = '0;
            state_next = S_IDLE;
          end
        end else begin
          if (nbr_ok) begin
            stack_we   = 1'b1;
            level_next = level + LW'(1);
          end
          dir_next = dir + 2'd1;
          if (dir == DIR_YM) begin
            state_next = S_POP;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/flood_fill_engine.sv =====
`timescale 1ns / 1ps
// Flood fill engine: canvas of RGBA pixels with write, read and 4-way flood fill.
// Channels: cmd (op, x_coord, y_coord, pixel_color) in, rsp (read_color, status) out,
// cfg (index 0 image_width, index 1 image_height) register writes; valid/ready on each.
// Every command word gives exactly one response word, in order.
// A write or no-op is queued from idle as it is accepted; a read is queued from S_READ
// after the canvas read. A fill reads the seed, then steps through pop, load and check
// per popped position, pushes each of four neighbors of a painted pixel (one neighbor
// push per cycle) and ends on a pop that finds the stack empty; single-port RAMs set this.
// Writes and range errors are accepted one per cycle while the response queue has space;
// a read or fill holds cmd.ready low until its response is queued.
// Responses go through a two-entry queue, so a new command is taken while one response
// waits; once both entries are full cmd.ready drops until rsp drains.
// Reset sets both sizes to 256, empties the queue and returns to idle. Canvas and stack
// contents are undefined until written; no clearing pass is run. Pixel (x, y) sits at
// address {y, x}, so the canvas RAM has 2**(2*clog2(MAX_DIM)) words.
// Write cfg only while idle. cfg.ready is always high.
module flood_fill_engine import ffe_pkg::*; #(
  parameter int MAX_DIM     = 256,
  parameter int STACK_DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst,
  ffe_cmd_if.sink    cmd,
  ffe_rsp_if.source  rsp,
  ffe_cfg_if.sink    cfg
);

  localparam int CW  = $clog2(MAX_DIM);
  localparam int DW  = CW + 1;
  localparam int CAW = 2 * CW;
  localparam int SAW = $clog2(STACK_DEPTH);

  logic [DIM_REG_W-1:0] width_reg;
  logic [DIM_REG_W-1:0] height_reg;
  logic [DW-1:0]        w_eff;
  logic [DW-1:0]        h_eff;

  logic                 canvas_we;
  logic                 canvas_re;
  logic [CAW-1:0]       canvas_addr;
  logic [COLOR_W-1:0]   canvas_wdata;
  logic [COLOR_W-1:0]   canvas_rdata;
  logic                 stack_we;
  logic                 stack_re;
  logic [SAW-1:0]       stack_addr;
  logic [CAW-1:0]       stack_wdata;
  logic [CAW-1:0]       stack_rdata;
  logic                 res_push;
  res_t                 res;
  logic                 res_space;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= DIM_RESET;
      height_reg <= DIM_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_WIDTH) begin
        width_reg <= cfg.data;
      end
      if (cfg.index == CFG_HEIGHT) begin
        height_reg <= cfg.data;
      end
    end
  end

  // Clamp sizes to 1..MAX_DIM
  always_comb begin
    priority if (width_reg == '0) begin
      w_eff = DW'(1);
    end else if (32'(width_reg) > 32'(MAX_DIM)) begin
      w_eff = DW'(MAX_DIM);
    end else begin
      w_eff = DW'(width_reg);
    end
    priority if (height_reg == '0) begin
      h_eff = DW'(1);
    end else if (32'(height_reg) > 32'(MAX_DIM)) begin
      h_eff = DW'(MAX_DIM);
    end else begin
      h_eff = DW'(height_reg);
    end
  end

  ffe_ctrl #(
    .MAX_DIM     (MAX_DIM),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .w_eff        (w_eff),
    .h_eff        (h_eff),
    .canvas_we    (canvas_we),
    .canvas_re    (canvas_re),
    .canvas_addr  (canvas_addr),
    .canvas_wdata (canvas_wdata),
    .canvas_rdata (canvas_rdata),
    .stack_we     (stack_we),
    .stack_re     (stack_re),
    .stack_addr   (stack_addr),
    .stack_wdata  (stack_wdata),
    .stack_rdata  (stack_rdata),
    .res_push     (res_push),
    .res          (res),
    .res_space    (res_space)
  );

  ffe_ram #(
    .DEPTH (2 ** CAW),
    .WIDTH (COLOR_W)
  ) u_canvas (
    .clk   (clk),
    .we    (canvas_we),
    .re    (canvas_re),
    .addr  (canvas_addr),
    .wdata (canvas_wdata),
    .rdata (canvas_rdata)
  );

  ffe_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (CAW)
  ) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .re    (stack_re),
    .addr  (stack_addr),
    .wdata (stack_wdata),
    .rdata (stack_rdata)
  );

  ffe_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .res   (res),
    .space (res_space),
    .rsp   (rsp)
  );

  a_push_has_space: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_space)
    else $error("response pushed into a full queue");

  a_canvas_one_access: assert property (@(posedge clk) disable iff (rst)
    !(canvas_we && canvas_re))
    else $error("canvas read and written in the same cycle");

  a_stack_one_access: assert property (@(posedge clk) disable iff (rst)
    !(stack_we && stack_re))
    else $error("stack read and written in the same cycle");

  a_accept_pushes_or_works: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |-> (res_push || canvas_re))
    else $error("accepted command neither answered nor started");

endmodule
